/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the XTEA block cipher RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define XT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition at one edge implies a consequence at the next edge
`define XT_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

/* design/xtea_pkg.sv */
// ---------------------------------------------------------------------------
// xtea_pkg
// Types and constants shared by the XTEA round pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package xtea_pkg;

   localparam int unsigned XT_WORD_W         = 32;
   localparam int unsigned XT_KEY_WORDS      = 4;
   localparam int unsigned XT_KEY_SEL_W      = 2;
   localparam int unsigned XT_KEY_SEL_SHIFT  = 11;
   localparam int unsigned XT_ROUNDS_DEFAULT = 32;
   localparam int unsigned XT_CSR_INDEX_W    = 2;

   // delta = 0x9E3779B9, applied as subtraction (or, to decrypt, addition) of its negation
   localparam logic [XT_WORD_W-1:0] XT_STEP  = 32'h61C8_8647;
   localparam logic [XT_WORD_W-1:0] XT_DELTA = 32'h9E37_79B9;

   // Operation codes carried in tuser
   localparam logic XT_ACT_ENCRYPT = 1'b0;
   localparam logic XT_ACT_DECRYPT = 1'b1;

   typedef logic [XT_KEY_WORDS-1:0][XT_WORD_W-1:0] xtea_key_type;

   // One block in flight through the rounds
   typedef struct packed {
      logic                 action;
      logic [XT_WORD_W-1:0] sum;
      logic [XT_WORD_W-1:0] v1;
      logic [XT_WORD_W-1:0] v0;
   } xtea_beat_type;

   // Result halves, laid out to match tdata (first half in the low bits)
   typedef struct packed {
      logic [XT_WORD_W-1:0] second;
      logic [XT_WORD_W-1:0] first;
   } xtea_pair_type;

endpackage

`default_nettype wire

/* design/xtea_cell.sv */
// ---------------------------------------------------------------------------
// xtea_cell
// One XTEA round as two registered half rounds; cells chain into the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module xtea_cell
   import xtea_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire xtea_key_type  key,
   input  wire logic          in_valid,
   input  wire xtea_beat_type in_beat,
   output logic               out_valid,
   output xtea_beat_type      out_beat
);

   localparam logic HALF_EARLY = 1'b0;
   localparam logic HALF_LATE  = 1'b1;

   // Half round. Encrypt: early half updates v0 (key by sum[1:0]) and steps sum,
   // late half updates v1 (key by sum[12:11]). Decrypt mirrors the order.
   function automatic xtea_beat_type half_round(input xtea_beat_type b,
                                                input xtea_key_type  k,
                                                input logic          late);
      xtea_beat_type            r;
      logic                     upd_v0;
      logic [XT_WORD_W-1:0]     src;
      logic [XT_WORD_W-1:0]     dst;
      logic [XT_WORD_W-1:0]     mixed;
      logic [XT_WORD_W-1:0]     keyed;
      logic [XT_WORD_W-1:0]     f;
      logic [XT_WORD_W-1:0]     res;
      logic [XT_KEY_SEL_W-1:0]  ksel;
      r      = b;
      upd_v0 = (b.action == late);
      src    = upd_v0 ? b.v1 : b.v0;
      dst    = upd_v0 ? b.v0 : b.v1;
      ksel   = upd_v0 ? b.sum[XT_KEY_SEL_W-1:0]
                      : b.sum[XT_KEY_SEL_SHIFT +: XT_KEY_SEL_W];
      mixed  = ((src << 4) ^ (src >> 5)) + src;
      keyed  = b.sum + k[ksel];
      f      = mixed ^ keyed;
      res    = (b.action == XT_ACT_DECRYPT) ? (dst - f) : (dst + f);
      if (upd_v0) begin
         r.v0 = res;
      end else begin
         r.v1 = res;
      end
      if (late == HALF_EARLY) begin
         r.sum = (b.action == XT_ACT_DECRYPT) ? (b.sum + XT_STEP) : (b.sum - XT_STEP);
      end
      return r;
   endfunction

   logic          mid_valid_ff;
   xtea_beat_type mid_beat_ff;
   logic          out_valid_ff;
   xtea_beat_type out_beat_ff;

   xtea_beat_type mid_beat_in;
   xtea_beat_type out_beat_in;

   assign mid_beat_in = half_round(in_beat, key, HALF_EARLY);
   assign out_beat_in = half_round(mid_beat_ff, key, HALF_LATE);

   // Two stages per round, shifting together with the rest of the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         mid_valid_ff <= in_valid;
         out_valid_ff <= mid_valid_ff;
         mid_beat_ff  <= mid_beat_in;
         out_beat_ff  <= out_beat_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_beat  = out_beat_ff;

endmodule

`default_nettype wire

/* design/xtea_out_buf.sv */
// ---------------------------------------------------------------------------
// xtea_out_buf
// Output register with a one-beat skid stage behind the round pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module xtea_out_buf
   import xtea_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire xtea_pair_type in_data,
   output logic               full,
   output logic               out_valid,
   input  wire logic          out_ready,
   output xtea_pair_type      out_data
);

   logic          out_valid_ff;
   xtea_pair_type out_data_ff;
   logic          skid_valid_ff;
   xtea_pair_type skid_data_ff;

   logic out_free;

   assign out_free = !out_valid_ff || out_ready;

   // Output slot loads from skid first; a beat that finds the slot busy parks
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_valid;
            out_data_ff  <= in_data;
         end
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= in_data;
      end
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

/* design/xtea_block_cipher.sv */
// ---------------------------------------------------------------------------
// xtea_block_cipher
// XTEA 64-bit block encrypt/decrypt engine, fully pipelined, ECB.
// ---------------------------------------------------------------------------
// Takes one 64-bit block per clock and returns one per clock, in order.
// The datapath is a chain of ROUNDS round cells, each two register stages
// deep, then the output register. req_tuser picks encrypt (0) or decrypt
// (1) per beat. The key lives in four 32-bit registers written via
// csr_we/csr_index/csr_wdata; change it only while no beat is in flight.
// A one-beat skid stage behind the pipeline lets a new beat in while a
// result waits; with the skid full the whole chain holds and req_tready
// drops.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module xtea_block_cipher
   import xtea_pkg::*;
#(
   parameter int unsigned ROUNDS = XT_ROUNDS_DEFAULT
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Block input
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [63:0]               req_tdata,  // [31:0] word_first, [63:32] word_second
   input  wire logic                      req_tuser,  // [0] action
   // Block output
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [63:0]                    rsp_tdata,  // [31:0] result_first, [63:32] result_second
   // Key registers
   input  wire logic                      csr_we,
   input  wire logic [XT_CSR_INDEX_W-1:0] csr_index,
   input  wire logic [XT_WORD_W-1:0]      csr_wdata
);

   // Starting sum for decryption: ROUNDS * delta, modulo 2^32
   localparam logic [63:0]          DEC_SUM_WIDE = 64'(ROUNDS) * 64'(XT_DELTA);
   localparam logic [XT_WORD_W-1:0] DEC_SUM_INIT = DEC_SUM_WIDE[XT_WORD_W-1:0];

   xtea_key_type  key_ff;

   logic          stage_valid [ROUNDS+1];
   xtea_beat_type stage_beat  [ROUNDS+1];

   logic          advance;
   logic          skid_full;
   logic          last_valid;
   xtea_pair_type last_pair;
   xtea_pair_type rsp_pair;

   // Key register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_we) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   // Chain moves whenever the skid stage has room
   assign advance    = !skid_full;
   assign req_tready = advance;

   // Entry beat
   assign stage_valid[0]       = req_tvalid;
   assign stage_beat[0].action = req_tuser;
   assign stage_beat[0].v0     = req_tdata[XT_WORD_W-1:0];
   assign stage_beat[0].v1     = req_tdata[2*XT_WORD_W-1:XT_WORD_W];
   assign stage_beat[0].sum    = (req_tuser == XT_ACT_DECRYPT) ? DEC_SUM_INIT : '0;

   // Round chain
   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      xtea_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .key       (key_ff),
         .in_valid  (stage_valid[r]),
         .in_beat   (stage_beat[r]),
         .out_valid (stage_valid[r+1]),
         .out_beat  (stage_beat[r+1])
      );
   end

   assign last_valid       = stage_valid[ROUNDS] && advance;
   assign last_pair.first  = stage_beat[ROUNDS].v0;
   assign last_pair.second = stage_beat[ROUNDS].v1;

   xtea_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (last_valid),
      .in_data   (last_pair),
      .full      (skid_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_pair)
   );

   assign rsp_tdata = rsp_pair;

   // Skid holds a beat only while the output slot is also occupied
   `XT_ASSERT(a_skid_behind_out, clock, reset, !skid_full || rsp_tvalid, "skid full with empty output")
   // A finished beat arriving at a stalled output must park in the skid
   `XT_ASSERT_NEXT(a_skid_catches, clock, reset, rsp_tvalid && !rsp_tready && last_valid, skid_full, "finished beat not parked")
   // A drained output slot frees the skid on the next edge
   `XT_ASSERT_NEXT(a_skid_drains, clock, reset, skid_full && rsp_tready, !skid_full && rsp_tvalid, "skid did not drain")

endmodule

`default_nettype wire

/* tb/xtea_block_cipher_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// xtea_block_cipher_tb
// Self-checking bench for the pipelined XTEA encrypt/decrypt engine.
// ---------------------------------------------------------------------------
// A short table of boundary blocks is sent under the all-zero reset key and
// again under the all-ones key. Six random phases follow, each loading a new
// key. Random blocks mix fully random words, boundary words, words with one
// bit set or clear, and round trips, where the last predicted output is sent
// back with the opposite action. Every result beat is compared against a
// bit-accurate model of the 32-round cipher. Both stream sides idle in
// random bursts, except in the second and the final random phase.
// ---------------------------------------------------------------------------

module xtea_block_cipher_tb;
   import xtea_pkg::*;

   localparam int NUM_ROUNDS  = XT_ROUNDS_DEFAULT;
   localparam int PIPE_DEPTH  = 2 * NUM_ROUNDS + 1;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_BEATS = 305;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_ROWS    = 12;

   // Key register map
   typedef enum logic [XT_CSR_INDEX_W-1:0] {
      CSR_KEY_WORD0 = 2'd0,
      CSR_KEY_WORD1 = 2'd1,
      CSR_KEY_WORD2 = 2'd2,
      CSR_KEY_WORD3 = 2'd3
   } csr_reg_type;

   typedef struct {
      logic        action;
      logic [31:0] first;
      logic [31:0] second;
   } block_row_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [63:0]               req_tdata  = '0;   // [31:0] word_first, [63:32] word_second
   logic                      req_tuser  = 1'b0; // [0] action
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [63:0]               rsp_tdata;         // [31:0] result_first, [63:32] result_second
   logic                      csr_we     = 1'b0;
   logic [XT_CSR_INDEX_W-1:0] csr_index  = '0;
   logic [XT_WORD_W-1:0]      csr_wdata  = '0;

   xtea_pair_type pending_halves[$];
   xtea_key_type  cipher_key = '0;
   xtea_pair_type last_pair  = '0;
   logic          last_action = XT_ACT_ENCRYPT;
   xtea_pair_type seen_pair, want_pair;

   int idle_pct     = 0;
   int stall_left   = 0;
   int cycle_count  = 0;
   int error_count  = 0;
   int checked_cnt  = 0;
   int encrypt_cnt  = 0;
   int decrypt_cnt  = 0;
   int round_trips  = 0;
   int keys_loaded  = 1;

   // Boundary blocks: zero, all ones, checkerboards, end bits, sample words
   block_row_type boundary_rows [NUM_ROWS] = '{
      '{XT_ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
      '{XT_ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{XT_ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000},
      '{XT_ACT_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{XT_ACT_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF},
      '{XT_ACT_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000},
      '{XT_ACT_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA},
      '{XT_ACT_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555},
      '{XT_ACT_ENCRYPT, 32'h8000_0000, 32'h0000_0001},
      '{XT_ACT_DECRYPT, 32'h0000_0001, 32'h8000_0000},
      '{XT_ACT_ENCRYPT, 32'h4142_4344, 32'h4546_4748},
      '{XT_ACT_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF}
   };

   int phase_idle [NUM_PHASES] = '{20, 0, 50, 10, 35, 0};

   xtea_block_cipher #(
      .ROUNDS(NUM_ROUNDS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Feistel mixing term shared by both halves
   function automatic logic [31:0] feistel_mix(input logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

   // Full 32-round XTEA transform of one block under the given key
   function automatic xtea_pair_type xtea_transform(input logic act,
                                                    input logic [31:0] w0,
                                                    input logic [31:0] w1,
                                                    input xtea_key_type key);
      logic [31:0]   v0, v1, sum;
      xtea_pair_type out;
      v0 = w0;
      v1 = w1;
      if (act == XT_ACT_DECRYPT) begin
         sum = 32'(NUM_ROUNDS) * XT_DELTA;
         for (int r = 0; r < NUM_ROUNDS; r++) begin
            v1  = v1 - (feistel_mix(v0) ^ (sum + key[sum[12:11]]));
            sum = sum + XT_STEP;
            v0  = v0 - (feistel_mix(v1) ^ (sum + key[sum[1:0]]));
         end
      end else begin
         sum = '0;
         for (int r = 0; r < NUM_ROUNDS; r++) begin
            v0  = v0 + (feistel_mix(v1) ^ (sum + key[sum[1:0]]));
            sum = sum - XT_STEP;
            v1  = v1 + (feistel_mix(v0) ^ (sum + key[sum[12:11]]));
         end
      end
      out.first  = v0;
      out.second = v1;
      return out;
   endfunction

   // Cycle watchdog
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time,
                  pending_halves.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left = stall_left - 1;
      else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2)
         stall_left = $urandom_range(1, 17);
      rsp_tready <= (stall_left == 0);
   end

   // Result checker: every accepted beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_pair = rsp_tdata;
         if (pending_halves.size() == 0) begin
            $display("%0t: unexpected result beat, got %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want_pair = pending_halves.pop_front();
            checked_cnt++;
            if (seen_pair.first !== want_pair.first) begin
               $display("%0t: result_first mismatch, expected %h got %h",
                        $time, want_pair.first, seen_pair.first);
               error_count++;
            end
            if (seen_pair.second !== want_pair.second) begin
               $display("%0t: result_second mismatch, expected %h got %h",
                        $time, want_pair.second, seen_pair.second);
               error_count++;
            end
         end
      end
   end

   // Drop valid and wait for the pipeline to hand back everything in flight
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_halves.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Key change only with the pipeline empty
   task automatic load_key(input xtea_key_type new_key);
      drain_results();
      write_csr(CSR_KEY_WORD0, new_key[0]);
      write_csr(CSR_KEY_WORD1, new_key[1]);
      write_csr(CSR_KEY_WORD2, new_key[2]);
      write_csr(CSR_KEY_WORD3, new_key[3]);
      csr_we     <= 1'b0;
      cipher_key  = new_key;
      keys_loaded++;
   endtask

   // One block beat, with an optional idle burst in front
   task automatic send_block(input logic act, input logic [31:0] w0,
                             input logic [31:0] w1);
      xtea_pair_type prediction;
      int            gap;
      prediction = xtea_transform(act, w0, w1, cipher_key);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w1, w0};
      req_tuser  <= act;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_halves.push_back(prediction);
      if (act == XT_ACT_DECRYPT)
         decrypt_cnt++;
      else
         encrypt_cnt++;
      last_pair   = prediction;
      last_action = act;
   endtask

   // Random word: mostly uniform, sometimes a boundary or a lone bit
   function automatic logic [31:0] pick_word();
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0: begin
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         end
         1: begin
            return 32'h1 << $urandom_range(0, 31);
         end
         2: begin
            return ~(32'h1 << $urandom_range(0, 31));
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   initial begin
      xtea_key_type phase_key;
      logic         act;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Boundary table under the reset key, then under the all-ones key
      idle_pct = 15;
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1)
            load_key('1);
         for (int i = 0; i < NUM_ROWS; i++)
            send_block(boundary_rows[i].action, boundary_rows[i].first,
                       boundary_rows[i].second);
      end

      // Random phases, one key each
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               phase_key = {32'h0C0D_0E0F, 32'h0809_0A0B, 32'h0405_0607, 32'h0001_0203};
            end
            2: begin
               phase_key = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
            end
            default: begin
               for (int k = 0; k < XT_KEY_WORDS; k++)
                  phase_key[k] = $urandom();
            end
         endcase
         // New idle level first, so the result side already stalls at it during the key load
         idle_pct = phase_idle[p];
         load_key(phase_key);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // Hold off mid-phase until the pipeline runs dry
            if (p == 2 && n == PHASE_BEATS / 2)
               drain_results();
            if ($urandom_range(0, 3) == 0) begin
               act = (last_action == XT_ACT_ENCRYPT) ? XT_ACT_DECRYPT : XT_ACT_ENCRYPT;
               round_trips++;
               send_block(act, last_pair.first, last_pair.second);
            end else begin
               act = $urandom_range(0, 1) ? XT_ACT_DECRYPT : XT_ACT_ENCRYPT;
               send_block(act, pick_word(), pick_word());
            end
         end
      end

      drain_results();
      repeat (PIPE_DEPTH + 16) @(posedge clock);

      $display("Sent %0d blocks (%0d encrypt, %0d decrypt, %0d round trips) under %0d keys.",
               encrypt_cnt + decrypt_cnt, encrypt_cnt, decrypt_cnt, round_trips,
               keys_loaded);
      $display("Checked %0d result beats, %0d mismatches.", checked_cnt, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
